// File: sv/pdcs_pkg.sv
// shared widths, register indexes, thresholds and pipeline types for the diffusion cell step
`default_nettype none

package pdcs_pkg;

    localparam int VAL_W  = 24;  // Q12.12 pressure
    localparam int MAG_W  = 23;  // saturated magnitude
    localparam int GRAD_W = 25;  // neighbour difference
    localparam int LAP_W  = 27;  // sum of four differences
    localparam int COEF_W = 15;
    localparam int DEC_W  = 17;
    localparam int PROD_W = 43;  // coef * lap
    localparam int T_W    = 44;  // here * 2^16 + coef * lap
    localparam int P_W    = 62;  // t * decay
    localparam int ROUND_SHIFT = 32;
    localparam int RND_W  = P_W - ROUND_SHIFT + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

    localparam logic [DEC_W-1:0] DECAY_RESET = 17'd65536;

    // |r| * 500 < 4096 flushes, i.e. |r| < 9
    localparam logic [MAG_W-1:0] FLUSH_MIN  = 23'd9;
    // |r| * 50 > 4096, i.e. |r| >= 82
    localparam logic [MAG_W-1:0] ACTIVE_MIN = 23'd82;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [P_W:0] ROUND_HALF = (P_W+1)'(1) << (ROUND_SHIFT - 1);

    // side information that rides along with every beat
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_z;
        logic                     kill;
        logic                     chunk_end;
    } t_carry;

endpackage

`default_nettype wire

// File: sv/pressure_diffusion_cell_step.sv
// Pressure diffusion cell step: one cell of a 5-point Jacobi diffusion sweep per beat.
// The block takes one cell per clock while the output is not stalled; the seven register
// stages (stencil, Laplacian sum, coefficient multiply, add, decay multiply,
// round/saturate, flush and peak) each hold one beat, so a cell can enter on every clock
// and a stalled output only backs up the stages that are full. The running chunk peak is
// kept at the last stage in arrival order.
// Configuration writes are always taken; the registers are read as a beat enters the
// first, third and fifth stages, so write them only while no beat is in flight.
`default_nettype none

module pressure_diffusion_cell_step (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [pdcs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [pdcs_pkg::CFG_DATA_W-1:0]       i_cfg_data,

    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [pdcs_pkg::VAL_W-1:0]     i_here_value,
    input  wire logic                                  i_here_wall,
    input  wire logic signed [pdcs_pkg::VAL_W-1:0]     i_east_value,
    input  wire logic signed [pdcs_pkg::VAL_W-1:0]     i_west_value,
    input  wire logic signed [pdcs_pkg::VAL_W-1:0]     i_north_value,
    input  wire logic signed [pdcs_pkg::VAL_W-1:0]     i_south_value,
    input  wire logic                                  i_east_wall,
    input  wire logic                                  i_west_wall,
    input  wire logic                                  i_north_wall,
    input  wire logic                                  i_south_wall,
    input  wire logic                                  i_chunk_quiet,
    input  wire logic                                  i_chunk_end,

    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [pdcs_pkg::VAL_W-1:0]          o_new_value,
    output logic                                       o_active,
    output logic signed [pdcs_pkg::GRAD_W-1:0]         o_grad_x_diff,
    output logic signed [pdcs_pkg::GRAD_W-1:0]         o_grad_z_diff,
    output logic [pdcs_pkg::MAG_W-1:0]                 o_chunk_peak,
    output logic                                       o_chunk_touched,
    output logic                                       o_chunk_done
);

    localparam int NSTG = 7;
    localparam int NDIR = 4;

    // configuration
    logic [pdcs_pkg::COEF_W-1:0] r_coef;
    logic [pdcs_pkg::DEC_W-1:0]  r_decay;
    logic [pdcs_pkg::MAG_W-1:0]  r_floor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= '0;
            r_decay <= pdcs_pkg::DECAY_RESET;
            r_floor <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pdcs_pkg::CFG_COEF:  r_coef  <= i_cfg_data[pdcs_pkg::COEF_W-1:0];
                pdcs_pkg::CFG_DECAY: r_decay <= i_cfg_data[pdcs_pkg::DEC_W-1:0];
                pdcs_pkg::CFG_FLOOR: r_floor <= i_cfg_data[pdcs_pkg::MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    logic [NSTG-1:0] n_vld;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld[0] = w_adv[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[NSTG-1];

    // stage 1: effective neighbours, propagation test, gradients
    logic signed [pdcs_pkg::VAL_W-1:0]  w_nb [NDIR];
    logic        [NDIR-1:0]             w_nwall;
    logic signed [pdcs_pkg::VAL_W-1:0]  w_nv [NDIR];
    logic        [pdcs_pkg::VAL_W-1:0]  w_nmag [NDIR];
    logic signed [pdcs_pkg::GRAD_W-1:0] w_diff [NDIR];
    pdcs_pkg::t_carry                   w_c0;

    assign w_nb[0] = i_east_value;
    assign w_nb[1] = i_west_value;
    assign w_nb[2] = i_north_value;
    assign w_nb[3] = i_south_value;
    assign w_nwall = {i_south_wall, i_north_wall, i_west_wall, i_east_wall};

    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            w_nv[d]   = w_nwall[d] ? i_here_value : w_nb[d];
            w_nmag[d] = w_nv[d][pdcs_pkg::VAL_W-1] ? (~w_nv[d] + 1'b1) : w_nv[d];
            if (w_nwall[d] || (w_nmag[d] < {1'b0, r_floor})) begin
                w_diff[d] = '0;
            end else begin
                w_diff[d] = pdcs_pkg::GRAD_W'(w_nv[d]) - pdcs_pkg::GRAD_W'(i_here_value);
            end
        end
        w_c0.kill      = i_here_wall || i_chunk_quiet;
        w_c0.chunk_end = i_chunk_end;
        if (w_c0.kill) begin
            w_c0.grad_x = '0;
            w_c0.grad_z = '0;
        end else begin
            w_c0.grad_x = pdcs_pkg::GRAD_W'(w_nv[0]) - pdcs_pkg::GRAD_W'(w_nv[1]);
            w_c0.grad_z = pdcs_pkg::GRAD_W'(w_nv[2]) - pdcs_pkg::GRAD_W'(w_nv[3]);
        end
    end

    logic signed [pdcs_pkg::GRAD_W-1:0] r_diff [NDIR];
    logic signed [pdcs_pkg::VAL_W-1:0]  r_here1, r_here2, r_here3;
    pdcs_pkg::t_carry                   r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_diff  <= w_diff;
            r_here1 <= i_here_value;
            r_c1    <= w_c0;
        end
    end

    // stage 2: laplacian
    logic signed [pdcs_pkg::LAP_W-1:0] r_lap;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_lap   <= pdcs_pkg::LAP_W'(r_diff[0]) + pdcs_pkg::LAP_W'(r_diff[1])
                     + pdcs_pkg::LAP_W'(r_diff[2]) + pdcs_pkg::LAP_W'(r_diff[3]);
            r_here2 <= r_here1;
            r_c2    <= r_c1;
        end
    end

    // stage 3: coef * lap
    logic signed [pdcs_pkg::PROD_W-1:0] w_prod;
    logic signed [pdcs_pkg::PROD_W-1:0] r_prod;

    assign w_prod = pdcs_pkg::PROD_W'(r_lap) * pdcs_pkg::PROD_W'($signed({1'b0, r_coef}));

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_prod  <= w_prod;
            r_here3 <= r_here2;
            r_c3    <= r_c2;
        end
    end

    // stage 4: here * 2^16 + coef * lap
    logic signed [pdcs_pkg::T_W-1:0] w_t;
    logic signed [pdcs_pkg::T_W-1:0] r_t;

    assign w_t = $signed({{(pdcs_pkg::T_W - pdcs_pkg::VAL_W - 16){r_here3[pdcs_pkg::VAL_W-1]}},
                          r_here3, 16'b0}) + pdcs_pkg::T_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_t  <= w_t;
            r_c4 <= r_c3;
        end
    end

    // stage 5: decay
    logic signed [pdcs_pkg::P_W-1:0] w_p;
    logic signed [pdcs_pkg::P_W-1:0] r_p;

    assign w_p = pdcs_pkg::P_W'(r_t) * pdcs_pkg::P_W'($signed({1'b0, r_decay}));

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_p  <= w_p;
            r_c5 <= r_c4;
        end
    end

    // stage 6: round and saturate
    logic [pdcs_pkg::MAG_W-1:0] w_mag;
    logic                       w_neg;
    logic [pdcs_pkg::MAG_W-1:0] r_mag;
    logic                       r_neg;

    pdcs_round u_round (
        .i_p   (r_p),
        .o_mag (w_mag),
        .o_neg (w_neg)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_mag <= w_mag;
            r_neg <= w_neg;
            r_c6  <= r_c5;
        end
    end

    // stage 7: flush, activity flag, chunk peak
    logic [pdcs_pkg::MAG_W-1:0] r_peak;
    logic [pdcs_pkg::MAG_W-1:0] w_peak_cand;
    logic                       w_live;
    logic                       w_load_last;

    assign w_live      = !r_c6.kill;
    assign w_peak_cand = (w_live && (r_mag > r_peak)) ? r_mag : r_peak;
    assign w_load_last = r_vld[NSTG-2] && w_adv[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (w_load_last) begin
            r_peak <= r_c6.chunk_end ? '0 : w_peak_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NSTG-1]) begin
            if (w_live && (r_mag >= pdcs_pkg::FLUSH_MIN)) begin
                o_new_value <= r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            end else begin
                o_new_value <= '0;
            end
            o_active        <= w_live && (r_mag >= pdcs_pkg::ACTIVE_MIN);
            o_grad_x_diff   <= r_c6.grad_x;
            o_grad_z_diff   <= r_c6.grad_z;
            o_chunk_peak    <= r_c6.chunk_end ? w_peak_cand : '0;
            o_chunk_touched <= r_c6.chunk_end && (w_peak_cand >= pdcs_pkg::ACTIVE_MIN);
            o_chunk_done    <= r_c6.chunk_end;
        end
    end

`ifndef SYNTHESIS
    a_peak_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_chunk_done) |-> (o_chunk_peak == '0 && !o_chunk_touched))
        else $error("chunk peak reported outside chunk end");

    a_active_not_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_active) |-> (o_new_value != '0))
        else $error("active result was flushed");

    a_touched_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_chunk_touched) |-> (o_chunk_peak >= pdcs_pkg::ACTIVE_MIN))
        else $error("chunk touched with small peak");

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_last && r_c6.chunk_end) |=> (r_peak == '0))
        else $error("running peak not cleared after chunk end");
`endif

endmodule

`default_nettype wire

// File: sv/pdcs_round.sv
// magnitude, round to nearest (ties away from zero) and saturation of the scaled product
`default_nettype none

module pdcs_round (
    input  wire logic signed [pdcs_pkg::P_W-1:0]   i_p,
    output logic             [pdcs_pkg::MAG_W-1:0] o_mag,
    output logic                                   o_neg
);

    logic [pdcs_pkg::P_W-1:0] w_abs;
    logic [pdcs_pkg::P_W:0]   w_sum;
    logic [pdcs_pkg::RND_W-1:0] w_rnd;

    assign o_neg = i_p[pdcs_pkg::P_W-1];
    assign w_abs = o_neg ? (~i_p + 1'b1) : i_p;
    assign w_sum = {1'b0, w_abs} + pdcs_pkg::ROUND_HALF;
    assign w_rnd = w_sum[pdcs_pkg::P_W:pdcs_pkg::ROUND_SHIFT];

    always_comb begin
        if (|w_rnd[pdcs_pkg::RND_W-1:pdcs_pkg::MAG_W]) begin
            o_mag = pdcs_pkg::MAG_MAX;
        end else begin
            o_mag = w_rnd[pdcs_pkg::MAG_W-1:0];
        end
    end

endmodule

`default_nettype wire
